// ----- hdl/sha1_pkg.sv -----
// sha1 engine package: request/response types, queue item type and algorithm constants
package sha1_pkg;

   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word0;
      logic [31:0] digest_word1;
      logic [31:0] digest_word2;
      logic [31:0] digest_word3;
      logic [31:0] digest_word4;
   } rsp_type;

   typedef struct packed {
      logic       is_finish;
      logic [7:0] data_byte;
   } q_item_type;

   typedef struct packed {
      logic       valid;
      q_item_type item;
   } q_out_type;

   localparam logic [4:0][31:0] H_INIT = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   localparam logic [3:0][31:0] ROUND_K = {
      32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
   };

   localparam logic [7:0] PAD_MARKER   = 8'h80;
   localparam logic [5:0] PAD_LEN_FILL = 6'd56;
   localparam logic [5:0] LAST_FILL    = 6'd63;
   localparam logic [6:0] ROUND_B1     = 7'd20;
   localparam logic [6:0] ROUND_B2     = 7'd40;
   localparam logic [6:0] ROUND_B3     = 7'd60;
   localparam logic [6:0] LAST_ROUND   = 7'd79;
   localparam logic [2:0] LAST_LEN_IDX = 3'd7;

endpackage

// ----- hdl/sha1_front.sv -----
// sha1 front end: request intake, classification and item queue
module sha1_front #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sha1_pkg::req_type   req_data,
   output sha1_pkg::q_out_type q_out,
   input  logic                q_pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sha1_pkg::q_item_type mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 push;
   sha1_pkg::q_item_type item;

   assign req_stall = (count_ff == CNT_W'(DEPTH));
   assign push      = req_valid && !req_stall;

   assign item.is_finish = (req_data.op == sha1_pkg::OP_FINISH);
   assign item.data_byte = req_data.data_byte;

   assign q_out.valid = (count_ff != '0);
   assign q_out.item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      priority if (push && !q_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (q_pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ----- hdl/sha1_back.sv -----
// sha1 back end: block window, padding sequencer, round unit and digest register
module sha1_back (
   input  logic                clock,
   input  logic                reset,
   input  sha1_pkg::q_out_type q_out,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sha1_pkg::rsp_type   rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ZERO,
      ST_LEN,
      ST_ROUND,
      ST_SUM,
      ST_EMIT
   } back_state_type;

   back_state_type    state_ff, state_in;
   back_state_type    ret_ff, ret_in;
   back_state_type    after_push;
   logic [5:0]        fill_ff, fill_in;
   logic [60:0]       count_ff, count_in;
   logic [2:0]        len_idx_ff, len_idx_in;
   logic [6:0]        round_ff, round_in;
   logic [4:0][31:0]  chain_ff, chain_in;
   logic [4:0][31:0]  work_ff, work_in;
   logic [511:0]      win_ff, win_in;
   logic              rsp_valid_ff, rsp_valid_in;
   sha1_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic              push_en;
   logic [7:0]        push_byte;
   logic [7:0][7:0]   len_bytes;
   logic [1:0]        stage;
   logic [31:0]       fn, t_sum, sched_new;
   logic [31:0]       wa, wb, wc, wd, we;

   assign len_bytes = {count_ff, 3'b000};

   assign wa = work_ff[0];
   assign wb = work_ff[1];
   assign wc = work_ff[2];
   assign wd = work_ff[3];
   assign we = work_ff[4];

   always_comb begin
      priority if (round_ff < sha1_pkg::ROUND_B1) begin
         stage = 2'd0;
      end else if (round_ff < sha1_pkg::ROUND_B2) begin
         stage = 2'd1;
      end else if (round_ff < sha1_pkg::ROUND_B3) begin
         stage = 2'd2;
      end else begin
         stage = 2'd3;
      end
   end

   always_comb begin
      unique case (stage)
         2'd0:    fn = (wb & wc) | (~wb & wd);
         2'd2:    fn = (wb & wc) | (wb & wd) | (wc & wd);
         default: fn = wb ^ wc ^ wd;
      endcase
   end

   assign t_sum = {wa[26:0], wa[31:27]} + fn + we + sha1_pkg::ROUND_K[stage]
                  + win_ff[511:480];

   always_comb begin
      logic [31:0] mix;
      mix       = win_ff[95:64] ^ win_ff[255:224] ^ win_ff[447:416] ^ win_ff[511:480];
      sched_new = {mix[30:0], mix[31]};
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      fill_in      = fill_ff;
      count_in     = count_ff;
      len_idx_in   = len_idx_ff;
      round_in     = round_ff;
      chain_in     = chain_ff;
      work_in      = work_ff;
      win_in       = win_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      push_en      = 1'b0;
      push_byte    = '0;
      after_push   = ST_IDLE;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_out.valid) begin
               q_pop   = 1'b1;
               push_en = 1'b1;
               if (q_out.item.is_finish) begin
                  push_byte  = sha1_pkg::PAD_MARKER;
                  len_idx_in = '0;
                  after_push = ST_ZERO;
               end else begin
                  push_byte  = q_out.item.data_byte;
                  count_in   = count_ff + 61'd1;
                  after_push = ST_IDLE;
               end
            end
         end
         ST_ZERO: begin
            if (fill_ff == sha1_pkg::PAD_LEN_FILL) begin
               state_in = ST_LEN;
            end else begin
               push_en    = 1'b1;
               after_push = ST_ZERO;
            end
         end
         ST_LEN: begin
            push_en    = 1'b1;
            push_byte  = len_bytes[3'd7 - len_idx_ff];
            len_idx_in = len_idx_ff + 3'd1;
            after_push = (len_idx_ff == sha1_pkg::LAST_LEN_IDX) ? ST_EMIT : ST_LEN;
         end
         ST_ROUND: begin
            work_in  = {wd, wc, {wb[1:0], wb[31:2]}, wa, t_sum};
            win_in   = {win_ff[479:0], sched_new};
            round_in = round_ff + 7'd1;
            if (round_ff == sha1_pkg::LAST_ROUND) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            for (int i = 0; i < 5; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            state_in = ret_ff;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.digest_word0  = chain_ff[0];
               rsp_data_in.digest_word1  = chain_ff[1];
               rsp_data_in.digest_word2  = chain_ff[2];
               rsp_data_in.digest_word3  = chain_ff[3];
               rsp_data_in.digest_word4  = chain_ff[4];
               chain_in                  = sha1_pkg::H_INIT;
               count_in                  = '0;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (push_en) begin
         win_in  = {win_ff[503:0], push_byte};
         fill_in = fill_ff + 6'd1;
         if (fill_ff == sha1_pkg::LAST_FILL) begin
            state_in = ST_ROUND;
            ret_in   = after_push;
            round_in = '0;
            work_in  = chain_ff;
         end else begin
            state_in = after_push;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         fill_ff      <= '0;
         count_ff     <= '0;
         len_idx_ff   <= '0;
         round_ff     <= '0;
         chain_ff     <= sha1_pkg::H_INIT;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         len_idx_ff   <= len_idx_in;
         round_ff     <= round_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      win_ff  <= win_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hdl/sha1_hash_engine.sv -----
// sha1 hash engine top level: request queue in front of the compression back end
// Each absorb request adds one byte to the block window in the back end, and every
// 64th byte adds an 80-round compression (one round per cycle) followed by a step
// that folds the result into the chaining value. A finish request pads in the back end
// one byte per cycle between compressions (9 to 72 pad bytes, with one or two
// compressions) and then loads the digest into the response register. Requests queue
// up to QUEUE_DEPTH deep while the back end is busy with a compression or padding,
// and the back end keeps working while a finished digest waits to be taken.
module sha1_hash_engine #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sha1_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sha1_pkg::rsp_type rsp_data
);

   sha1_pkg::q_out_type q_out;
   logic                q_pop;

   sha1_front #(
      .DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_out     (q_out),
      .q_pop     (q_pop)
   );

   sha1_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_out     (q_out),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- hdl/sha1_chk.sv -----
// sha1 engine port checker and its bind to the top level
module sha1_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input sha1_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input sha1_pkg::rsp_type rsp_data
);

   logic [7:0] pending_ff, pending_in;
   logic       fin_taken, rsp_taken;

   assign fin_taken = req_valid && !req_stall && (req_data.op == sha1_pkg::OP_FINISH);
   assign rsp_taken = rsp_valid && !rsp_stall;

   always_comb begin
      pending_in = pending_ff;
      priority if (fin_taken && !rsp_taken) begin
         pending_in = pending_ff + 8'd1;
      end else if (rsp_taken && !fin_taken) begin
         pending_in = pending_ff - 8'd1;
      end else begin
         pending_in = pending_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // clean start after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("outputs not idle after reset");

   // every digest answers an earlier finish request
   a_rsp_has_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 8'd0)
      else $error("digest without a pending finish request");

   // a stalled digest holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled digest changed");

endmodule

bind sha1_hash_engine sha1_chk u_sha1_chk (.*);

// ----- test/tb_sha1_hash_engine.sv -----
// testbench for sha1_hash_engine: random byte streams checked against a SHA-1 predictor
module tb_sha1_hash_engine;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_kind_type;

   class sha1_digest_model;
      logic [31:0]       chain [5];
      logic [7:0]        block [64];
      int unsigned       fill;
      logic [60:0]       msg_bytes;
      sha1_pkg::rsp_type digests_due [$];
      int unsigned       mismatches;
      int unsigned       digests_checked;

      function new();
         mismatches      = 0;
         digests_checked = 0;
         restart();
      endfunction

      function void restart();
         for (int i = 0; i < 5; i++) chain[i] = sha1_pkg::H_INIT[i];
         fill      = 0;
         msg_bytes = '0;
      endfunction

      function logic [31:0] rol(logic [31:0] x, int unsigned s);
         return (x << s) | (x >> (32 - s));
      endfunction

      function void compress();
         logic [31:0] w [80];
         logic [31:0] a, b, c, d, e, f, k, t;
         for (int r = 0; r < 16; r++)
            w[r] = {block[4*r], block[4*r+1], block[4*r+2], block[4*r+3]};
         for (int r = 16; r < 80; r++)
            w[r] = rol(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
         a = chain[0];
         b = chain[1];
         c = chain[2];
         d = chain[3];
         e = chain[4];
         for (int r = 0; r < 80; r++) begin
            if (r < sha1_pkg::ROUND_B1) begin
               f = (b & c) | (~b & d);
               k = sha1_pkg::ROUND_K[0];
            end else if (r < sha1_pkg::ROUND_B2) begin
               f = b ^ c ^ d;
               k = sha1_pkg::ROUND_K[1];
            end else if (r < sha1_pkg::ROUND_B3) begin
               f = (b & c) | (b & d) | (c & d);
               k = sha1_pkg::ROUND_K[2];
            end else begin
               f = b ^ c ^ d;
               k = sha1_pkg::ROUND_K[3];
            end
            t = rol(a, 5) + f + e + k + w[r];
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
         end
         chain[0] += a;
         chain[1] += b;
         chain[2] += c;
         chain[3] += d;
         chain[4] += e;
      endfunction

      function void push_byte(logic [7:0] v);
         block[fill] = v;
         fill++;
         if (fill == 64) begin
            compress();
            fill = 0;
         end
      endfunction

      function void note_request(sha1_pkg::req_type r);
         logic [63:0]       bit_len;
         sha1_pkg::rsp_type digest;
         if (r.op == sha1_pkg::OP_ABSORB) begin
            push_byte(r.data_byte);
            msg_bytes++;
         end else begin
            bit_len = {msg_bytes, 3'b000};
            push_byte(sha1_pkg::PAD_MARKER);
            while (fill != sha1_pkg::PAD_LEN_FILL) push_byte(8'h00);
            for (int i = 7; i >= 0; i--) push_byte(bit_len[8*i +: 8]);
            digest.digest_word0 = chain[0];
            digest.digest_word1 = chain[1];
            digest.digest_word2 = chain[2];
            digest.digest_word3 = chain[3];
            digest.digest_word4 = chain[4];
            digests_due = {digests_due, digest};
            restart();
         end
      endfunction

      function int unsigned pending();
         return digests_due.size();
      endfunction

      task report_mismatch(string msg);
         if (mismatches < 40) $display("%0t ns: mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task compare_word(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("digest %0d %s: got %h, expected %h",
                                      digests_checked, name, got, want));
      endtask

      task check_digest(sha1_pkg::rsp_type got);
         sha1_pkg::rsp_type want;
         if (digests_due.size() == 0) begin
            report_mismatch($sformatf("digest %h with no request pending", got));
            return;
         end
         want = digests_due.pop_front();
         compare_word("word0", got.digest_word0, want.digest_word0);
         compare_word("word1", got.digest_word1, want.digest_word1);
         compare_word("word2", got.digest_word2, want.digest_word2);
         compare_word("word3", got.digest_word3, want.digest_word3);
         compare_word("word4", got.digest_word4, want.digest_word4);
         digests_checked++;
      endtask
   endclass

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   sha1_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   sha1_pkg::rsp_type rsp_data;

   sha1_digest_model tracker;
   int unsigned      requests_sent = 0;
   int unsigned      finishes_sent = 0;
   int unsigned      longest_msg   = 0;
   bit               sender_burst  = 1'b0;
   bit               receiver_burst = 1'b0;
   int               boundary_len [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

   sha1_hash_engine DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic sha1_pkg::req_type mk_request(logic op, logic [7:0] b);
      sha1_pkg::req_type r;
      r.op        = op;
      r.data_byte = b;
      return r;
   endfunction

   task automatic send_request(sha1_pkg::req_type r);
      int unsigned gap;
      gap = sender_burst ? 0 : $urandom_range(0, 15);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      tracker.note_request(r);
      requests_sent++;
      if (r.op == sha1_pkg::OP_FINISH) finishes_sent++;
   endtask

   task automatic send_message(int unsigned len, fill_kind_type kind);
      sha1_pkg::req_type r;
      for (int i = 0; i < len; i++) begin
         r.op = sha1_pkg::OP_ABSORB;
         case (kind)
            FILL_ZERO: r.data_byte = 8'h00;
            FILL_ONES: r.data_byte = 8'hFF;
            default:   r.data_byte = 8'($urandom);
         endcase
         send_request(r);
      end
      send_request(mk_request(sha1_pkg::OP_FINISH, 8'($urandom)));
      if (len > longest_msg) longest_msg = len;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) tracker.check_digest(rsp_data);
   end

   initial begin
      int unsigned hold;
      forever begin
         if ($urandom_range(0, 5) == 0) receiver_burst = !receiver_burst;
         hold = receiver_burst ? 0 : $urandom_range(0, 15);
         if (hold != 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
      end
   end

   initial begin
      int unsigned   len;
      fill_kind_type kind;
      tracker = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty messages, single extreme bytes, short known strings
      send_request(mk_request(sha1_pkg::OP_FINISH, 8'hFF));
      send_request(mk_request(sha1_pkg::OP_FINISH, 8'h00));
      send_request(mk_request(sha1_pkg::OP_ABSORB, 8'h00));
      send_request(mk_request(sha1_pkg::OP_FINISH, 8'h5A));
      send_request(mk_request(sha1_pkg::OP_ABSORB, 8'hFF));
      send_request(mk_request(sha1_pkg::OP_FINISH, 8'hA5));
      send_request(mk_request(sha1_pkg::OP_ABSORB, 8'h61));
      send_request(mk_request(sha1_pkg::OP_ABSORB, 8'h62));
      send_request(mk_request(sha1_pkg::OP_ABSORB, 8'h63));
      send_request(mk_request(sha1_pkg::OP_FINISH, 8'h00));
      send_request(mk_request(sha1_pkg::OP_ABSORB, 8'h80));
      send_request(mk_request(sha1_pkg::OP_ABSORB, 8'h7F));
      send_request(mk_request(sha1_pkg::OP_ABSORB, 8'h55));
      send_request(mk_request(sha1_pkg::OP_ABSORB, 8'hAA));
      send_request(mk_request(sha1_pkg::OP_ABSORB, 8'h01));
      send_request(mk_request(sha1_pkg::OP_ABSORB, 8'hFE));
      send_request(mk_request(sha1_pkg::OP_FINISH, 8'hFF));
      drain();

      while (requests_sent < 1500 || finishes_sent < 36) begin
         sender_burst = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 11))
            0, 1, 2, 3, 4, 5, 6: len = $urandom_range(0, 8);
            7, 8:                len = boundary_len[$urandom_range(0, 8)];
            9, 10:               len = $urandom_range(9, 140);
            default:             len = $urandom_range(141, 200);
         endcase
         case ($urandom_range(0, 7))
            0:       kind = FILL_ZERO;
            1:       kind = FILL_ONES;
            default: kind = FILL_RANDOM;
         endcase
         send_message(len, kind);
         if ($urandom_range(0, 7) == 0) drain();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      $display("sent %0d requests forming %0d messages, longest %0d bytes, random gaps and stalls",
               requests_sent, finishes_sent, longest_msg);
      $display("compared %0d digests, %0d mismatches", tracker.digests_checked,
               tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("** sha1_hash_engine: PASSED **");
      end else begin
         $display("** sha1_hash_engine: FAILED **");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("timeout: run did not complete");
      $display("** sha1_hash_engine: FAILED **");
      $finish;
   end

endmodule

// ----- sha1_hash_engine.f -----
hdl/sha1_pkg.sv
hdl/sha1_front.sv
hdl/sha1_back.sv
hdl/sha1_hash_engine.sv
hdl/sha1_chk.sv
test/tb_sha1_hash_engine.sv
